### hdl/gimli_pkg.sv
// types, constants and the round function of the gimli permutation pipeline
package gimli_pkg;

   localparam int GIMLI_ROUNDS = 24;
   localparam int FIRST_ROUND = 24;
   localparam int NUM_WORDS = 12;
   localparam int WORD_WIDTH = 32;
   localparam int ROUND_NUM_WIDTH = 5;
   localparam logic [WORD_WIDTH-1:0] ROUND_CONST = 32'h9e377900;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [ROUND_NUM_WIDTH-1:0] round_num_type;

   // state word i, row = i / 4, column = i % 4
   typedef logic [NUM_WORDS-1:0][WORD_WIDTH-1:0] state_type;

   typedef struct packed {
      word_type in_word_0;
      word_type in_word_1;
      word_type in_word_2;
      word_type in_word_3;
      word_type in_word_4;
      word_type in_word_5;
      word_type in_word_6;
      word_type in_word_7;
      word_type in_word_8;
      word_type in_word_9;
      word_type in_word_10;
      word_type in_word_11;
   } req_payload_type;

   typedef struct packed {
      word_type out_word_0;
      word_type out_word_1;
      word_type out_word_2;
      word_type out_word_3;
      word_type out_word_4;
      word_type out_word_5;
      word_type out_word_6;
      word_type out_word_7;
      word_type out_word_8;
      word_type out_word_9;
      word_type out_word_10;
      word_type out_word_11;
   } rsp_payload_type;

   function automatic word_type rotl(input word_type v, input int n);
      return (v << n) | (v >> (WORD_WIDTH - n));
   endfunction

   // one full round: sp-box on all four columns, swap/constant by r mod 4
   function automatic state_type gimli_round(input state_type st, input round_num_type r);
      state_type nxt;
      word_type a;
      word_type b;
      word_type d;
      word_type t;
      nxt = st;
      for (int c = 0; c < 4; c++) begin
         a = rotl(st[c], 24);
         b = rotl(st[4 + c], 9);
         d = st[8 + c];
         nxt[8 + c] = a ^ (d << 1) ^ ((b & d) << 2);
         nxt[4 + c] = b ^ a ^ ((a | d) << 1);
         nxt[c] = d ^ b ^ ((a & b) << 3);
      end
      case (r[1:0])
         2'd0: begin
            // small swap plus round constant
            t = nxt[0];
            nxt[0] = nxt[1] ^ ROUND_CONST ^ {{(WORD_WIDTH - ROUND_NUM_WIDTH){1'b0}}, r};
            nxt[1] = t;
            t = nxt[2];
            nxt[2] = nxt[3];
            nxt[3] = t;
         end
         2'd2: begin
            // big swap
            t = nxt[0];
            nxt[0] = nxt[2];
            nxt[2] = t;
            t = nxt[1];
            nxt[1] = nxt[3];
            nxt[3] = t;
         end
         default: begin
         end
      endcase
      return nxt;
   endfunction

endpackage

### hdl/gimli_chan_if.sv
// valid/ready channel carrying one word of the given payload type
interface gimli_chan_if #(
   parameter type payload_type = logic
) ();
   logic valid;
   logic ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hdl/gimli_stage.sv
// one pipeline stage: a single gimli round followed by the stage register
module gimli_stage #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  gimli_pkg::state_type in_state,
   output logic                 out_valid,
   input  logic                 out_ready,
   output gimli_pkg::state_type out_state
);
   import gimli_pkg::*;

   localparam round_num_type RoundNum = ROUND_NUM_WIDTH'(FIRST_ROUND - STAGE);

   logic      valid_ff;
   logic      valid_in;
   state_type state_ff;
   state_type state_in;

   // stage takes a word when empty or when its word moves on
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign state_in = gimli_round(in_state, RoundNum);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
endmodule

### hdl/permutation_384_24_round_top.sv
// top level of the gimli 384-bit permutation pipeline
// The block applies ROUNDS rounds of the Gimli permutation (default 24, rounds
// 24 down to 25 - ROUNDS) to a 384-bit state given as twelve 32-bit words.
// There is one register stage per round. A new word can be accepted in every
// cycle while the result side takes its words: one word per cycle sustained
// without stalls. Each stage holds its word under back-pressure and frees as
// soon as its word moves on, so empty stages fill up while the result side
// stalls and nothing is lost or repeated.
module permutation_384_24_round_top #(
   parameter int ROUNDS = gimli_pkg::GIMLI_ROUNDS
) (
   input logic         clock,
   input logic         reset,
   gimli_chan_if.sink   req_chan,
   gimli_chan_if.source rsp_chan
);
   import gimli_pkg::*;

   logic      stage_valid [ROUNDS+1];
   logic      stage_ready [ROUNDS+1];
   state_type stage_state [ROUNDS+1];

   assign stage_valid[0]  = req_chan.valid;
   assign req_chan.ready  = stage_ready[0];
   assign stage_state[0][0]  = req_chan.data.in_word_0;
   assign stage_state[0][1]  = req_chan.data.in_word_1;
   assign stage_state[0][2]  = req_chan.data.in_word_2;
   assign stage_state[0][3]  = req_chan.data.in_word_3;
   assign stage_state[0][4]  = req_chan.data.in_word_4;
   assign stage_state[0][5]  = req_chan.data.in_word_5;
   assign stage_state[0][6]  = req_chan.data.in_word_6;
   assign stage_state[0][7]  = req_chan.data.in_word_7;
   assign stage_state[0][8]  = req_chan.data.in_word_8;
   assign stage_state[0][9]  = req_chan.data.in_word_9;
   assign stage_state[0][10] = req_chan.data.in_word_10;
   assign stage_state[0][11] = req_chan.data.in_word_11;

   for (genvar k = 0; k < ROUNDS; k++) begin : g_round
      gimli_stage #(
         .STAGE(k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_state  (stage_state[k]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_state (stage_state[k+1])
      );
   end

   assign rsp_chan.valid         = stage_valid[ROUNDS];
   assign stage_ready[ROUNDS]    = rsp_chan.ready;
   assign rsp_chan.data.out_word_0  = stage_state[ROUNDS][0];
   assign rsp_chan.data.out_word_1  = stage_state[ROUNDS][1];
   assign rsp_chan.data.out_word_2  = stage_state[ROUNDS][2];
   assign rsp_chan.data.out_word_3  = stage_state[ROUNDS][3];
   assign rsp_chan.data.out_word_4  = stage_state[ROUNDS][4];
   assign rsp_chan.data.out_word_5  = stage_state[ROUNDS][5];
   assign rsp_chan.data.out_word_6  = stage_state[ROUNDS][6];
   assign rsp_chan.data.out_word_7  = stage_state[ROUNDS][7];
   assign rsp_chan.data.out_word_8  = stage_state[ROUNDS][8];
   assign rsp_chan.data.out_word_9  = stage_state[ROUNDS][9];
   assign rsp_chan.data.out_word_10 = stage_state[ROUNDS][10];
   assign rsp_chan.data.out_word_11 = stage_state[ROUNDS][11];
endmodule

### dv/testbench.sv
// testbench for the gimli 384-bit permutation pipeline
`timescale 1ns / 1ps

module testbench;
   import gimli_pkg::*;

   localparam int N_ROUNDS = GIMLI_ROUNDS;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gimli_chan_if #(.payload_type(req_payload_type)) req_if ();
   gimli_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   permutation_384_24_round_top #(.ROUNDS(N_ROUNDS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   rsp_payload_type expected_states[$];
   int mismatch_count = 0;
   bit sender_steady = 1'b0;
   bit receiver_steady = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted state after all rounds, rounds counted down from the first
   function automatic rsp_payload_type gimli_permute(input req_payload_type st_in);
      word_type w [NUM_WORDS];
      word_type top;
      word_type mid;
      word_type bot;
      word_type t;
      rsp_payload_type res;
      int rnd;
      for (int i = 0; i < NUM_WORDS; i++)
         w[i] = st_in[(NUM_WORDS - 1 - i) * WORD_WIDTH +: WORD_WIDTH];
      for (rnd = FIRST_ROUND; rnd > FIRST_ROUND - N_ROUNDS; rnd--) begin
         for (int c = 0; c < 4; c++) begin
            top = {w[c][7:0], w[c][31:8]};
            mid = {w[4 + c][22:0], w[4 + c][31:23]};
            bot = w[8 + c];
            w[8 + c] = top ^ (bot << 1) ^ ((mid & bot) << 2);
            w[4 + c] = mid ^ top ^ ((top | bot) << 1);
            w[c] = bot ^ mid ^ ((top & mid) << 3);
         end
         if (rnd % 4 == 0) begin
            t = w[0]; w[0] = w[1]; w[1] = t;
            t = w[2]; w[2] = w[3]; w[3] = t;
            w[0] = w[0] ^ ROUND_CONST ^ word_type'(rnd);
         end else if (rnd % 4 == 2) begin
            t = w[0]; w[0] = w[2]; w[2] = t;
            t = w[1]; w[1] = w[3]; w[3] = t;
         end
      end
      for (int i = 0; i < NUM_WORDS; i++)
         res[(NUM_WORDS - 1 - i) * WORD_WIDTH +: WORD_WIDTH] = w[i];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input word_type got, input word_type want);
      mismatch_count++;
      $display("%0t ns: %s: got %08h expected %08h", $time, what, got, want);
   endtask

   // no gap half the time, otherwise mostly short gaps and a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic word_type pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return word_type'(1) << $urandom_range(0, WORD_WIDTH - 1);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_payload_type pick_state();
      req_payload_type st;
      for (int i = 0; i < NUM_WORDS; i++)
         st[i * WORD_WIDTH +: WORD_WIDTH] = pick_word();
      return st;
   endfunction

   // result side: random stalls unless held steady
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0 && !receiver_steady) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = 0;
            if (!receiver_steady && $urandom_range(0, 5) == 0)
               stall_left = pick_gap() + 1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_states.size() == 0) begin
            report_mismatch("result word with nothing pending", rsp_if.data[WORD_WIDTH-1:0], '0);
         end else begin
            want = expected_states.pop_front();
            for (int i = 0; i < NUM_WORDS; i++) begin
               if (rsp_if.data[(NUM_WORDS - 1 - i) * WORD_WIDTH +: WORD_WIDTH] !==
                   want[(NUM_WORDS - 1 - i) * WORD_WIDTH +: WORD_WIDTH])
                  report_mismatch($sformatf("out_word_%0d", i),
                     rsp_if.data[(NUM_WORDS - 1 - i) * WORD_WIDTH +: WORD_WIDTH],
                     want[(NUM_WORDS - 1 - i) * WORD_WIDTH +: WORD_WIDTH]);
            end
         end
      end
   end

   task automatic send_state(input req_payload_type st);
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.data <= st;
      do @(posedge clock); while (!req_if.ready);
      expected_states.push_back(gimli_permute(st));
   endtask

   task automatic idle_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
   endtask

   task automatic send_with_gap(input req_payload_type st);
      send_state(st);
      if (!sender_steady)
         idle_sender(pick_gap());
   endtask

   task automatic wait_drained();
      while (expected_states.size() != 0)
         @(posedge clock);
   endtask

   // all zero, all one, one word set at a time, alternating bits, counting words
   task automatic test_extremes();
      req_payload_type st;
      send_with_gap('0);
      send_with_gap('1);
      for (int i = 0; i < NUM_WORDS; i++) begin
         st = '0;
         st[(NUM_WORDS - 1 - i) * WORD_WIDTH +: WORD_WIDTH] = '1;
         send_with_gap(st);
      end
      send_with_gap({NUM_WORDS{32'haaaaaaaa}});
      send_with_gap({NUM_WORDS{32'h55555555}});
      for (int i = 0; i < NUM_WORDS; i++)
         st[(NUM_WORDS - 1 - i) * WORD_WIDTH +: WORD_WIDTH] = word_type'(i);
      send_with_gap(st);
      idle_sender(1);
   endtask

   // one word per cycle with no stalls on either side
   task automatic test_full_rate();
      sender_steady = 1'b1;
      receiver_steady = 1'b1;
      repeat (200) send_with_gap(pick_state());
      idle_sender(1);
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
   endtask

   // sender holds off until the pipeline is empty, then resumes
   task automatic test_drain_pause();
      repeat (3) begin
         repeat (40) send_with_gap(pick_state());
         idle_sender(1);
         wait_drained();
      end
   endtask

   task automatic test_random();
      repeat (30) begin
         sender_steady = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         repeat (50) send_with_gap(pick_state());
      end
      idle_sender(1);
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_full_rate();
      test_drain_pause();
      test_random();
      wait_drained();
      repeat (N_ROUNDS + 16) @(posedge clock);
      if (expected_states.size() != 0)
         report_mismatch("results still pending", '0, '0);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
